// File: hdl/c8ie_pkg.sv
`default_nettype none
package c8ie_pkg;
    localparam int MEM_BYTES_D   = 4096;
    localparam int STACK_DEPTH_D = 16;
    localparam int SCREEN_W_D    = 64;
    localparam int SCREEN_H_D    = 32;
    localparam logic [11:0] FONT_BASE = 12'd50;
    localparam logic [11:0] PC_RESET  = 12'd512;

    localparam logic [1:0] OP_EXEC  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_ROW   = 2'd3;

    localparam logic [15:0] INS_CLS = 16'h00E0;
    localparam logic [15:0] INS_RET = 16'h00EE;
    localparam logic [7:0] KK_SKP  = 8'h9E;
    localparam logic [7:0] KK_SKNP = 8'hA1;
    localparam logic [7:0] KK_LDDT = 8'h07;
    localparam logic [7:0] KK_WKEY = 8'h0A;
    localparam logic [7:0] KK_SDT  = 8'h15;
    localparam logic [7:0] KK_SST  = 8'h18;
    localparam logic [7:0] KK_ADDI = 8'h1E;
    localparam logic [7:0] KK_FONT = 8'h29;
    localparam logic [7:0] KK_BCD  = 8'h33;
    localparam logic [7:0] KK_STOR = 8'h55;
    localparam logic [7:0] KK_LOAD = 8'h65;
    localparam logic [7:0] NO_KEY  = 8'hFF;

    function automatic logic [7:0] font_byte(input logic [6:0] a);
        logic [7:0] f;
        begin
            case (a)
                7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22, 7'd25, 7'd27,
                7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42, 7'd44, 7'd45, 7'd47,
                7'd49, 7'd50, 7'd52, 7'd60, 7'd64, 7'd70, 7'd72, 7'd74, 7'd75, 7'd77:
                    f = 8'hF0;
                7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46, 7'd51, 7'd53,
                7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68: f = 8'h90;
                7'd5, 7'd7, 7'd8, 7'd37: f = 8'h20;
                7'd6: f = 8'h60;
                7'd9: f = 8'h70;
                7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: f = 8'h10;
                7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76, 7'd78,
                7'd79: f = 8'h80;
                7'd38, 7'd39: f = 8'h40;
                7'd55, 7'd57, 7'd59, 7'd65, 7'd69: f = 8'hE0;
                default: f = 8'h00;
            endcase
            return f;
        end
    endfunction

    typedef struct packed {
        logic       we;
        logic [11:0] waddr;
        logic [7:0] wdata;
        logic [11:0] raddr;
    } t_mem_req;
endpackage
`default_nettype wire

// File: hdl/chip8_instruction_engine_unit.sv
`default_nettype none
// Channel | Dir | Contents
// s_axis  | in  | tdata: op[1:0] key_code[9:2] random_byte[17:10] mem_addr[29:18]
//         |     |        mem_data[37:30] row_select[42:38]
// m_axis  | out | tdata: pc_now[11:0] row_pixels[75:12] sound_active[76]
//         |     |        waiting_key[77] collision[78]
// Registered reads of main memory and screen RAM set the time to a result: tick and write are
// answered from idle, a row read waits on screen RAM, an execute fetches two bytes and decodes,
// a draw reads, merges and writes each sprite row, BCD writes its digits, block moves go one
// register at a time (a load waits on its first read), and clear screen writes every row. After
// reset a pass over all of main memory writes zeros and the font and clears the screen; no transfer is
// taken meanwhile. The result waits in an output register; s_axis_tready is low until it is taken.
module chip8_instruction_engine_unit
    import c8ie_pkg::*;
#(
    parameter int MEM_BYTES   = MEM_BYTES_D,
    parameter int STACK_DEPTH = STACK_DEPTH_D,
    parameter int SCREEN_W    = SCREEN_W_D,
    parameter int SCREEN_H    = SCREEN_H_D
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // op, key_code, random_byte, mem_addr, mem_data, row_select
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata   // pc_now, row_pixels, sound_active, waiting_key, collision
);
    localparam int HW = $clog2(SCREEN_H);
    localparam int SW = $clog2(STACK_DEPTH);

    typedef enum logic [11:0] {
        S_INIT  = 12'b000000000001, S_IDLE  = 12'b000000000010,
        S_F0    = 12'b000000000100, S_F1    = 12'b000000001000,
        S_F2    = 12'b000000010000, S_EXEC  = 12'b000000100000,
        S_CLS   = 12'b000001000000, S_DRD   = 12'b000010000000,
        S_DSC   = 12'b000100000000, S_DWR   = 12'b001000000000,
        S_BLK   = 12'b010000000000, S_ROW   = 12'b100000000000
    } t_state;

    t_state r_st;
    logic [11:0] r_cnt;
    logic [11:0] r_pc, r_i;
    logic [SW-1:0] r_sp;
    logic [7:0] r_dt, r_stm, r_hi, r_lo, r_sprite;
    logic [7:0] r_v [16];
    logic [11:0] r_stk [STACK_DEPTH];
    logic [47:0] r_in;
    logic r_hit;
    logic [79:0] r_out;
    logic r_ov;

    t_mem_req w_req;
    logic [7:0] w_rd;
    logic w_swe;
    logic [HW-1:0] w_swa, w_sra;
    logic [SCREEN_W-1:0] w_swd, w_srd;

    c8ie_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (.i_clk, .i_req(w_req), .o_rdata(w_rd));
    c8ie_screen #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_scr (
        .i_clk, .i_we(w_swe), .i_waddr(w_swa), .i_wdata(w_swd), .i_raddr(w_sra),
        .o_rdata(w_srd));

    wire [15:0] w_ins = {r_hi, r_lo};
    wire [3:0] w_x = r_hi[3:0];
    wire [3:0] w_y = r_lo[7:4];
    wire [3:0] w_n = r_lo[3:0];
    wire [7:0] w_vx = r_v[w_x];
    wire [7:0] w_vy = r_v[w_y];
    wire [7:0] w_key = r_in[9:2];
    wire [3:0] w_c4 = r_cnt[3:0];

    logic [SCREEN_W-1:0] w_mask;
    always_comb begin
        w_mask = '0;
        for (int j = 0; j < 8; j++) begin
            if (r_sprite[7-j]) w_mask[6'(w_vx + 8'(j))] = 1'b1;
        end
    end

    // w_q = vx / 10 by reciprocal multiply
    logic [7:0] w_bcd, w_q;
    always_comb begin
        w_q = 8'((16'(w_vx) * 16'd205) >> 11);
        if (w_c4 == 4'd0) w_bcd = (w_vx >= 8'd200) ? 8'd2 : (w_vx >= 8'd100) ? 8'd1 : 8'd0;
        else if (w_c4 == 4'd1) w_bcd = (w_q >= 8'd20) ? w_q - 8'd20 :
                                       (w_q >= 8'd10) ? w_q - 8'd10 : w_q;
        else w_bcd = w_vx - 8'(10 * w_q);
    end

    assign s_axis_tready = (r_st == S_IDLE) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;
    wire w_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_req = '0;
        w_swe = 1'b0;
        w_swa = '0;
        w_swd = w_srd ^ w_mask;
        w_sra = s_axis_tdata[38 +: HW];
        case (r_st)
            S_INIT: begin
                w_req.we = 1'b1;
                w_req.waddr = r_cnt;
                w_req.wdata = (r_cnt >= FONT_BASE && r_cnt < FONT_BASE + 12'd80) ?
                              font_byte(7'(r_cnt - FONT_BASE)) : 8'd0;
                w_swe = (r_cnt < 12'(SCREEN_H));
                w_swa = r_cnt[HW-1:0];
                w_swd = '0;
            end
            S_IDLE: begin
                w_req.raddr = r_pc;
                if (w_acc && s_axis_tdata[1:0] == OP_WRITE) begin
                    w_req.we = 1'b1;
                    w_req.waddr = s_axis_tdata[29:18];
                    w_req.wdata = s_axis_tdata[37:30];
                end
            end
            S_F0: w_req.raddr = r_pc + 12'd1;
            S_CLS: begin
                w_swe = 1'b1;
                w_swa = r_cnt[HW-1:0];
                w_swd = '0;
            end
            S_DRD: w_req.raddr = r_i + r_cnt;
            S_DSC: w_sra = HW'(w_vy + r_cnt[7:0]);
            S_DWR: begin
                w_swe = 1'b1;
                w_swa = HW'(w_vy + r_cnt[7:0]);
            end
            S_BLK: begin
                w_req.raddr = r_i + r_cnt;
                if (r_lo == KK_BCD) begin
                    w_req.we = 1'b1;
                    w_req.waddr = r_i + r_cnt;
                    w_req.wdata = w_bcd;
                end else if (r_lo == KK_STOR) begin
                    w_req.we = 1'b1;
                    w_req.waddr = r_i + r_cnt;
                    w_req.wdata = r_v[w_c4];
                end
            end
            default: ;
        endcase
    end

    task automatic done(input logic [11:0] pc, input logic [63:0] px, input logic wk,
                        input logic co, input logic [7:0] st);
        r_out <= {co, wk, (st != 8'd0), px, pc};
        r_pc <= pc;
        r_ov <= 1'b1;
        r_st <= S_IDLE;
    endtask

    logic [8:0] w_sum;
    logic [11:0] w_pc2;
    assign w_sum = {1'b0, w_vx} + {1'b0, w_vy};
    assign w_pc2 = r_pc + 12'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT;
            r_cnt <= '0;
            r_pc <= PC_RESET;
            r_i <= '0;
            r_sp <= '0;
            r_dt <= '0;
            r_stm <= '0;
            r_ov <= 1'b0;
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
            for (int k = 0; k < STACK_DEPTH; k++) r_stk[k] <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ov <= 1'b0;
            case (r_st)
                S_INIT: begin
                    r_cnt <= r_cnt + 12'd1;
                    if (r_cnt == 12'(MEM_BYTES - 1)) r_st <= S_IDLE;
                end
                S_IDLE: if (w_acc) begin
                    r_in <= s_axis_tdata;
                    case (s_axis_tdata[1:0])
                        OP_EXEC: r_st <= S_F0;
                        OP_TICK: begin
                            if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                            if (r_stm != 8'd0) r_stm <= r_stm - 8'd1;
                            done(r_pc, 64'd0, 1'b0, 1'b0,
                                 (r_stm != 8'd0) ? r_stm - 8'd1 : 8'd0);
                        end
                        OP_WRITE: done(r_pc, 64'd0, 1'b0, 1'b0, r_stm);
                        default: r_st <= S_ROW;
                    endcase
                end
                S_ROW: done(r_pc, w_srd, 1'b0, 1'b0, r_stm);
                S_F0: begin
                    r_hi <= w_rd;
                    r_st <= S_F1;
                end
                S_F1: begin
                    r_lo <= w_rd;
                    r_st <= S_F2;
                end
                S_F2: r_st <= S_EXEC;
                S_EXEC: begin
                    r_cnt <= '0;
                    r_hit <= 1'b0;
                    case (r_hi[7:4])
                        4'h0: begin
                            if (w_ins == INS_CLS) begin
                                r_pc <= w_pc2;
                                r_st <= S_CLS;
                            end else if (w_ins == INS_RET) begin
                                r_sp <= r_sp - 1'b1;
                                done(r_stk[r_sp], 64'd0, 1'b0, 1'b0, r_stm);
                            end else done(w_pc2, 64'd0, 1'b0, 1'b0, r_stm);
                        end
                        4'h1: begin
                            done(w_ins[11:0], 64'd0, 1'b0, 1'b0, r_stm);
                        end
                        4'h2: begin
                            r_sp <= r_sp + 1'b1;
                            r_stk[r_sp + 1'b1] <= w_pc2;
                            done(w_ins[11:0], 64'd0, 1'b0, 1'b0, r_stm);
                        end
                        4'h3, 4'h4, 4'h5, 4'h9: begin
                            logic sk;
                            sk = (r_hi[7:4] == 4'h3) ? (w_vx == r_lo) :
                                 (r_hi[7:4] == 4'h4) ? (w_vx != r_lo) :
                                 (r_hi[7:4] == 4'h5) ? (w_vx == w_vy) : (w_vx != w_vy);
                            done(sk ? r_pc + 12'd4 : w_pc2, 64'd0, 1'b0, 1'b0, r_stm);
                        end
                        4'hE: begin
                            logic sk;
                            sk = (r_lo == KK_SKP && w_key == w_vx) ||
                                 (r_lo == KK_SKNP && w_key != w_vx);
                            done(sk ? r_pc + 12'd4 : w_pc2, 64'd0, 1'b0, 1'b0, r_stm);
                        end
                        4'hB: begin
                            done(w_ins[11:0] + {4'd0, r_v[0]}, 64'd0, 1'b0, 1'b0, r_stm);
                        end
                        4'hD: begin
                            if (w_n == 4'd0) done(w_pc2, 64'd0, 1'b0, 1'b0, r_stm);
                            else begin
                                r_pc <= w_pc2;
                                r_st <= S_DRD;
                            end
                            if (w_n == 4'd0) r_v[15] <= 8'd0;
                        end
                        4'hF: begin
                            case (r_lo)
                                KK_WKEY: begin
                                    if (w_key == NO_KEY) begin
                                        done(r_pc, 64'd0, 1'b1, 1'b0, r_stm);
                                    end else begin
                                        r_v[w_x] <= w_key;
                                        done(w_pc2, 64'd0, 1'b0, 1'b0, r_stm);
                                    end
                                end
                                KK_BCD, KK_STOR, KK_LOAD: begin
                                    r_pc <= w_pc2;
                                    r_st <= S_BLK;
                                end
                                KK_SST: begin
                                    r_stm <= w_vx;
                                    done(w_pc2, 64'd0, 1'b0, 1'b0, w_vx);
                                end
                                default: begin
                                    case (r_lo)
                                        KK_LDDT: r_v[w_x] <= r_dt;
                                        KK_SDT:  r_dt <= w_vx;
                                        KK_ADDI: r_i <= r_i + {4'd0, w_vx};
                                        KK_FONT: r_i <= FONT_BASE + 12'(w_vx * 12'd5);
                                        default: ;
                                    endcase
                                    done(w_pc2, 64'd0, 1'b0, 1'b0, r_stm);
                                end
                            endcase
                        end
                        default: begin
                            case (r_hi[7:4])
                                4'h6: r_v[w_x] <= r_lo;
                                4'h7: r_v[w_x] <= w_vx + r_lo;
                                4'hA: r_i <= w_ins[11:0];
                                4'hC: r_v[w_x] <= r_in[17:10] & r_lo;
                                4'h8: begin
                                    case (w_n)
                                        4'h0: r_v[w_x] <= w_vy;
                                        4'h1: r_v[w_x] <= w_vx | w_vy;
                                        4'h2: r_v[w_x] <= w_vx & w_vy;
                                        4'h3: r_v[w_x] <= w_vx ^ w_vy;
                                        4'h4: begin
                                            if (w_x != 4'hF) r_v[w_x] <= w_sum[7:0];
                                            r_v[15] <= {7'd0, w_sum[8]};
                                        end
                                        4'h5: begin
                                            if (w_x != 4'hF) r_v[w_x] <= w_vx - w_vy;
                                            r_v[15] <= {7'd0, w_vx >= w_vy};
                                        end
                                        4'h6: begin
                                            if (w_x != 4'hF) r_v[w_x] <= w_vx >> 1;
                                            r_v[15] <= {7'd0, w_vx[0]};
                                        end
                                        4'h7: begin
                                            if (w_x != 4'hF) r_v[w_x] <= w_vy - w_vx;
                                            r_v[15] <= {7'd0, w_vy >= w_vx};
                                        end
                                        4'hE: begin
                                            if (w_x != 4'hF) r_v[w_x] <= w_vx << 1;
                                            r_v[15] <= {7'd0, w_vx[7]};
                                        end
                                        default: ;
                                    endcase
                                end
                                default: ;
                            endcase
                            done(w_pc2, 64'd0, 1'b0, 1'b0, r_stm);
                        end
                    endcase
                end
                S_CLS: begin
                    r_cnt <= r_cnt + 12'd1;
                    if (r_cnt == 12'(SCREEN_H - 1)) done(r_pc, 64'd0, 1'b0, 1'b0, r_stm);
                end
                S_DRD: r_st <= S_DSC;
                S_DSC: begin
                    r_sprite <= w_rd;
                    r_st <= S_DWR;
                end
                S_DWR: begin
                    logic h;
                    h = r_hit || ((w_srd & w_mask) != '0);
                    r_hit <= h;
                    r_cnt <= r_cnt + 12'd1;
                    if (r_cnt[3:0] == w_n - 4'd1) begin
                        r_v[15] <= {7'd0, h};
                        done(r_pc, 64'd0, 1'b0, h, r_stm);
                    end else r_st <= S_DRD;
                end
                S_BLK: begin
                    logic [3:0] last;
                    last = (r_lo == KK_BCD) ? 4'd2 : w_x;
                    r_cnt <= r_cnt + 12'd1;
                    if (r_lo == KK_LOAD) begin
                        if (r_cnt != 12'd0) r_v[w_c4 - 4'd1] <= w_rd;
                        if (r_cnt == {7'd0, 1'b0, last} + 12'd1)
                            done(r_pc, 64'd0, 1'b0, 1'b0, r_stm);
                    end else if (w_c4 == last && r_cnt[11:4] == 8'd0)
                        done(r_pc, 64'd0, 1'b0, 1'b0, r_stm);
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_st))
        else $error("state not one-hot");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken with result pending");
endmodule
`default_nettype wire

// File: hdl/c8ie_mem.sv
`default_nettype none
module c8ie_mem
    import c8ie_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_D
) (
    input  wire logic       i_clk,
    input  wire t_mem_req   i_req,
    output logic [7:0]      o_rdata
);
    localparam int AW = $clog2(MEM_BYTES);
    logic [7:0] r_mem [MEM_BYTES];
    always_ff @(posedge i_clk) begin
        if (i_req.we) r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        o_rdata <= r_mem[i_req.raddr[AW-1:0]];
    end
endmodule
`default_nettype wire

// File: hdl/c8ie_screen.sv
`default_nettype none
module c8ie_screen
    import c8ie_pkg::*;
#(
    parameter int SCREEN_W = SCREEN_W_D,
    parameter int SCREEN_H = SCREEN_H_D
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [$clog2(SCREEN_H)-1:0] i_waddr,
    input  wire logic [SCREEN_W-1:0]         i_wdata,
    input  wire logic [$clog2(SCREEN_H)-1:0] i_raddr,
    output logic [SCREEN_W-1:0]              o_rdata
);
    logic [SCREEN_W-1:0] r_scr [SCREEN_H];
    always_ff @(posedge i_clk) begin
        if (i_we) r_scr[i_waddr] <= i_wdata;
        o_rdata <= r_scr[i_raddr];
    end
endmodule
`default_nettype wire
